@@ rtl/flmec_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flmec_pkg
// Shared types and constants of the frame LSB metadata embedder / checker.
// ---------------------------------------------------------------------------
package flmec_pkg;

  localparam int unsigned SIZE_W     = 24;
  localparam int unsigned SPACING_W  = 17;   // frame size / 192 fits in 17 bits
  localparam int unsigned BITNUM_W   = 8;    // counts 0..192
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned META_BITS  = 192;

  localparam logic [31:0]         META_MAGIC       = 32'h5643_414D;
  localparam logic [SIZE_W-1:0]   FRAME_SIZE_RESET = 24'd1382400;
  localparam logic [SPACING_W-1:0] SPACING_RESET   =
    SPACING_W'(FRAME_SIZE_RESET / META_BITS);

  // Division by three of an 18-bit value: (x * DIV3_MUL) >> DIV3_SHIFT.
  localparam logic [17:0] DIV3_MUL   = 18'd174763;
  localparam int unsigned DIV3_SHIFT = 19;

  localparam logic MODE_EMBED = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FRAME_SIZE = 1'b0,
    CFG_MODE       = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_INDEX   = 3'd3,
    ST_COUNTER = 3'd4,
    ST_TIME    = 3'd5
  } status_e;

  typedef struct packed {
    logic [63:0] stamp;
    logic [63:0] counter;
    logic [31:0] index;
    logic        last;
    logic        first;
    logic [7:0]  data;
  } in_beat_t;

  typedef struct packed {
    status_e    status;
    logic       status_valid;
    logic       last;
    logic [7:0] data;
  } out_beat_t;

  // Field that carries metadata bit k.
  function automatic status_e field_of(logic [BITNUM_W-1:0] k);
    status_e f;
    if (k < 8'd32) begin
      f = ST_MAGIC;
    end else if (k < 8'd64) begin
      f = ST_INDEX;
    end else if (k < 8'd128) begin
      f = ST_COUNTER;
    end else begin
      f = ST_TIME;
    end
    return f;
  endfunction

endpackage

@@ rtl/frame_lsb_metadata_embed_check.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_lsb_metadata_embed_check
// Embeds or checks a 192-bit metadata record in the byte LSBs of a frame.
// ---------------------------------------------------------------------------
// Bytes of a frame enter one beat at a time and leave one beat per input
// beat, through an input register, then the embed / check logic,
// then an output register. A new beat is taken every cycle as long as the
// output side keeps taking results; the output register and the input
// register together absorb one stalled beat. The metadata record (magic,
// buffer index, frame counter, timestamp, each LSB first) sits in the LSB of
// every spacing-th byte, spacing being the frame size divided by 192. The
// spacing is recomputed by one reciprocal multiply when the frame size
// register is written. Configure only while no beat is in flight.
module frame_lsb_metadata_embed_check #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // tdata: data_byte[7:0], buf_idx[39:8], frame_seq[103:40],
  //        timestamp[167:104]
  input  logic [167:0] s_axis_tdata_i,
  input  logic         s_axis_tuser_i,   // first_byte
  input  logic         s_axis_tlast_i,   // last_byte
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: data_out[7:0], check_status[10:8], zero padding[15:11]
  output logic [15:0]  m_axis_tdata_o,
  output logic         m_axis_tuser_o,   // status_valid
  output logic         m_axis_tlast_o,   // last_out
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [flmec_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [flmec_pkg::SIZE_W-1:0]        cfg_data_i
);

  logic [flmec_pkg::SIZE_W-1:0]    frame_size_q;
  logic [flmec_pkg::SPACING_W-1:0] spacing_q, spacing_d;
  logic                            mode_q;
  flmec_pkg::in_beat_t             in_q;
  logic                            in_valid_q;
  flmec_pkg::out_beat_t            out_q, result;
  logic                            out_valid_q;
  logic                            advance;
  logic                            s_fire;

  assign cfg_ready_o = 1'b1;

  flmec_spacing u_spacing (
    .size_i    (cfg_data_i),
    .spacing_o (spacing_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= flmec_pkg::FRAME_SIZE_RESET;
      spacing_q    <= flmec_pkg::SPACING_RESET;
      mode_q       <= flmec_pkg::MODE_EMBED;
    end else if (cfg_valid_i) begin
      unique case (flmec_pkg::cfg_reg_e'(cfg_addr_i))
        flmec_pkg::CFG_FRAME_SIZE: begin
          frame_size_q <= cfg_data_i;
          spacing_q    <= spacing_d;
        end
        flmec_pkg::CFG_MODE: begin
          mode_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // The logic stage moves when its result can land in the output register.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_q <= '{stamp:   s_axis_tdata_i[167:104],
                counter: s_axis_tdata_i[103:40],
                index:   s_axis_tdata_i[39:8],
                last:    s_axis_tlast_i,
                first:   s_axis_tuser_i,
                data:    s_axis_tdata_i[7:0]};
    end
    if (advance) begin
      out_q <= result;
    end
  end

  flmec_core #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .beat_i       (in_q),
    .mode_i       (mode_q),
    .frame_size_i (frame_size_q),
    .spacing_i    (spacing_q),
    .result_o     (result)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_q.status, out_q.data};
  assign m_axis_tuser_o  = out_q.status_valid;
  assign m_axis_tlast_o  = out_q.last;

  // A status is only ever reported on the last beat of a frame.
  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("status reported on a beat that is not the last");

  // Without a valid status the status code stays zero.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[10:8] == 3'd0)
    else $error("status code set without status valid");

  // The status code never exceeds the timestamp mismatch code.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[10:8] <= 3'd5)
    else $error("status code out of range");

  // The bit spacing never drops to zero, whatever frame size is written.
  a_spacing_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spacing_q != '0)
    else $error("metadata bit spacing is zero");

endmodule

@@ rtl/flmec_spacing.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flmec_spacing
// Metadata bit spacing: frame size divided by 192, never below one.
// ---------------------------------------------------------------------------
module flmec_spacing (
  input  logic [flmec_pkg::SIZE_W-1:0]    size_i,
  output logic [flmec_pkg::SPACING_W-1:0] spacing_o
);

  logic [17:0] size_div64;
  logic [35:0] product;
  logic [flmec_pkg::SPACING_W-1:0] quotient;

  // 192 = 64 * 3: shift away the power of two, then divide by three
  // with a reciprocal multiply that is exact for all 18-bit values.
  assign size_div64 = size_i[flmec_pkg::SIZE_W-1:6];
  assign product    = 36'(size_div64) * 36'(flmec_pkg::DIV3_MUL);
  assign quotient   = product[flmec_pkg::DIV3_SHIFT +: flmec_pkg::SPACING_W];
  assign spacing_o  = (quotient == '0) ? flmec_pkg::SPACING_W'(1) : quotient;

endmodule

@@ rtl/flmec_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flmec_core
// Per-frame state and the single-pass embed / check logic for one beat.
// ---------------------------------------------------------------------------
module flmec_core #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  flmec_pkg::in_beat_t             beat_i,
  input  logic                            mode_i,
  input  logic [flmec_pkg::SIZE_W-1:0]    frame_size_i,
  input  logic [flmec_pkg::SPACING_W-1:0] spacing_i,
  output flmec_pkg::out_beat_t            result_o
);

  logic [POSITION_WIDTH-1:0]         pos_q, pos_d, pos_cur;
  logic [flmec_pkg::SPACING_W-1:0]   cd_q, cd_d, cd_cur;
  logic [flmec_pkg::BITNUM_W-1:0]    bn_q, bn_d, bn_cur;
  flmec_pkg::status_e                mm_q, mm_d, mm_cur;
  logic [31:0]                       index_q, index_cur;
  logic [63:0]                       counter_q, counter_cur;
  logic [63:0]                       stamp_q, stamp_cur;
  logic [flmec_pkg::META_BITS-1:0]   meta;
  logic                              hit;
  logic                              meta_bit;
  logic                              len_bad;

  // A first beat restarts the frame before the beat itself is handled.
  assign pos_cur     = beat_i.first ? '0 : pos_q;
  assign cd_cur      = beat_i.first ? '0 : cd_q;
  assign bn_cur      = beat_i.first ? '0 : bn_q;
  assign mm_cur      = beat_i.first ? flmec_pkg::ST_OK : mm_q;
  assign index_cur   = beat_i.first ? beat_i.index : index_q;
  assign counter_cur = beat_i.first ? beat_i.counter : counter_q;
  assign stamp_cur   = beat_i.first ? beat_i.stamp : stamp_q;

  assign meta     = {stamp_cur, counter_cur, index_cur, flmec_pkg::META_MAGIC};
  assign hit      = (bn_cur < flmec_pkg::BITNUM_W'(flmec_pkg::META_BITS)) && (cd_cur == '0);
  assign meta_bit = hit ? meta[bn_cur] : 1'b0;
  assign len_bad  = (33'(pos_cur) + 33'd1) != 33'(frame_size_i);

  always_comb begin
    pos_d    = pos_cur;
    cd_d     = cd_cur;
    bn_d     = bn_cur;
    mm_d     = mm_cur;
    result_o = '{status: flmec_pkg::ST_OK, status_valid: 1'b0,
                 last: beat_i.last, data: beat_i.data};

    if (hit) begin
      if (mode_i == flmec_pkg::MODE_EMBED) begin
        result_o.data = {beat_i.data[7:1], meta_bit};
      end else if ((beat_i.data[0] != meta_bit) && (mm_cur == flmec_pkg::ST_OK)) begin
        mm_d = flmec_pkg::field_of(bn_cur);
      end
      bn_d = bn_cur + flmec_pkg::BITNUM_W'(1);
      cd_d = spacing_i - flmec_pkg::SPACING_W'(1);
    end else if (cd_cur != '0) begin
      cd_d = cd_cur - flmec_pkg::SPACING_W'(1);
    end

    if (beat_i.last) begin
      if (mode_i == flmec_pkg::MODE_CHECK) begin
        result_o.status_valid = 1'b1;
        if (len_bad) begin
          result_o.status = flmec_pkg::ST_LENGTH;
        end else if (mm_d != flmec_pkg::ST_OK) begin
          result_o.status = mm_d;
        end else if (bn_d < flmec_pkg::BITNUM_W'(flmec_pkg::META_BITS)) begin
          // Frame ended before every metadata bit was seen.
          result_o.status = flmec_pkg::field_of(bn_d);
        end
      end
      pos_d = '0;
      cd_d  = '0;
      bn_d  = '0;
      mm_d  = flmec_pkg::ST_OK;
    end else if (pos_cur != '1) begin
      pos_d = pos_cur + POSITION_WIDTH'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      cd_q      <= '0;
      bn_q      <= '0;
      mm_q      <= flmec_pkg::ST_OK;
      index_q   <= '0;
      counter_q <= '0;
      stamp_q   <= '0;
    end else if (advance_i) begin
      pos_q     <= pos_d;
      cd_q      <= cd_d;
      bn_q      <= bn_d;
      mm_q      <= mm_d;
      index_q   <= index_cur;
      counter_q <= counter_cur;
      stamp_q   <= stamp_cur;
    end
  end

endmodule

@@ tb/metadata_frame_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// metadata_frame_checker
// Watches the byte stream, the result stream and the register channel of the
// frame LSB metadata embedder / checker. It predicts every result beat from
// its own copy of the frame state and compares the beats in order.
// ---------------------------------------------------------------------------
module metadata_frame_checker #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: data_byte, buf_idx, frame_seq, timestamp
  input  logic [167:0]                     s_axis_tdata_i,
  input  logic                             s_axis_tuser_i,   // first_byte
  input  logic                             s_axis_tlast_i,   // last_byte
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_o,
  // tdata: data_out, check_status, zero padding
  input  logic [15:0]                      m_axis_tdata_o,
  input  logic                             m_axis_tuser_o,   // status_valid
  input  logic                             m_axis_tlast_o,   // last_out
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  logic [flmec_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [flmec_pkg::SIZE_W-1:0]     cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       status_valid;
    logic [2:0] status_code;
  } frame_result_t;

  logic [flmec_pkg::SIZE_W-1:0] frame_size;
  logic                         op_mode;
  logic [POSITION_WIDTH-1:0]    byte_pos;
  logic [flmec_pkg::SIZE_W-1:0] spacing;
  logic [flmec_pkg::SIZE_W-1:0] countdown;
  logic [7:0]                   bit_num;
  logic [31:0]                  held_index;
  logic [63:0]                  held_counter;
  logic [63:0]                  held_stamp;
  flmec_pkg::status_e           first_bad;

  frame_result_t expected_results[$];
  int fails = 0;

  function automatic logic [flmec_pkg::SIZE_W-1:0] spacing_for_size(
      logic [flmec_pkg::SIZE_W-1:0] size);
    logic [flmec_pkg::SIZE_W-1:0] s;
    s = size / flmec_pkg::SIZE_W'(flmec_pkg::META_BITS);
    return (s == '0) ? flmec_pkg::SIZE_W'(1) : s;
  endfunction

  // Record layout: magic in bits 0..31, index 32..63, counter 64..127,
  // timestamp 128..191.
  function automatic flmec_pkg::status_e field_holding(logic [7:0] k);
    flmec_pkg::status_e f;
    if (k[7]) begin
      f = flmec_pkg::ST_TIME;
    end else if (k[6]) begin
      f = flmec_pkg::ST_COUNTER;
    end else if (k[5]) begin
      f = flmec_pkg::ST_INDEX;
    end else begin
      f = flmec_pkg::ST_MAGIC;
    end
    return f;
  endfunction

  task automatic restart_frame();
    byte_pos  = '0;
    countdown = '0;
    bit_num   = '0;
    first_bad = flmec_pkg::ST_OK;
  endtask

  task automatic embed_or_check(input logic [167:0] beat, input logic first,
                                input logic last, output frame_result_t r);
    logic [191:0] record;
    logic [7:0]   din;
    logic         mbit;
    din = beat[7:0];
    if (first) begin
      restart_frame();
      held_index   = beat[39:8];
      held_counter = beat[103:40];
      held_stamp   = beat[167:104];
    end
    record = {held_stamp, held_counter, held_index, flmec_pkg::META_MAGIC};
    r.data         = din;
    r.last         = last;
    r.status_valid = 1'b0;
    r.status_code  = flmec_pkg::ST_OK;

    if (bit_num < 8'(flmec_pkg::META_BITS) && countdown == '0) begin
      mbit = record[bit_num];
      if (op_mode == flmec_pkg::MODE_EMBED) begin
        r.data[0] = mbit;
      end else if (din[0] != mbit && first_bad == flmec_pkg::ST_OK) begin
        first_bad = field_holding(bit_num);
      end
      bit_num   = bit_num + 8'd1;
      countdown = spacing - flmec_pkg::SIZE_W'(1);
    end else if (countdown != '0) begin
      countdown = countdown - flmec_pkg::SIZE_W'(1);
    end

    if (last) begin
      if (op_mode == flmec_pkg::MODE_CHECK) begin
        r.status_valid = 1'b1;
        // Length comes first, then the first bad field, then missing bits.
        if (33'(byte_pos) + 33'd1 != 33'(frame_size)) begin
          r.status_code = flmec_pkg::ST_LENGTH;
        end else if (first_bad != flmec_pkg::ST_OK) begin
          r.status_code = first_bad;
        end else if (bit_num < 8'(flmec_pkg::META_BITS)) begin
          r.status_code = field_holding(bit_num);
        end
      end
      restart_frame();
    end else if (byte_pos != '1) begin
      byte_pos = byte_pos + POSITION_WIDTH'(1);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst_ni) begin
      frame_size   = flmec_pkg::FRAME_SIZE_RESET;
      op_mode      = flmec_pkg::MODE_EMBED;
      spacing      = spacing_for_size(flmec_pkg::FRAME_SIZE_RESET);
      held_index   = '0;
      held_counter = '0;
      held_stamp   = '0;
      restart_frame();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (flmec_pkg::cfg_reg_e'(cfg_addr_i))
          flmec_pkg::CFG_FRAME_SIZE: begin
            frame_size = cfg_data_i;
            spacing    = spacing_for_size(cfg_data_i);
          end
          flmec_pkg::CFG_MODE: begin
            op_mode = cfg_data_i[0];
          end
          default: ;
        endcase
      end

      if (s_axis_tvalid_i && s_axis_tready_o) begin
        embed_or_check(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i, want);
        expected_results.insert(expected_results.size(), want);
      end

      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.data         = m_axis_tdata_o[7:0];
        got.status_code  = m_axis_tdata_o[10:8];
        got.status_valid = m_axis_tuser_o;
        got.last         = m_axis_tlast_o;
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, expected none, actual %0h",
                   $time, m_axis_tdata_o);
        end else begin
          want = expected_results.pop_front();
          check_field("data_out", want.data, got.data);
          check_field("last_out", 8'(want.last), 8'(got.last));
          check_field("status_valid", 8'(want.status_valid), 8'(got.status_valid));
          check_field("check_status", 8'(want.status_code), 8'(got.status_code));
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives frames of bytes through the LSB metadata embedder / checker in both
// modes and over many frame sizes, with random gaps and output stalls, and
// takes the verdict from the result checker.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned RANDOM_BEATS = 1900;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic [167:0]                     s_axis_tdata_i  = '0;
  logic                             s_axis_tuser_i  = 1'b0;
  logic                             s_axis_tlast_i  = 1'b0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [15:0]                      m_axis_tdata_o;
  logic                             m_axis_tuser_o;
  logic                             m_axis_tlast_o;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic                             cfg_valid_i     = 1'b0;
  logic                             cfg_ready_o;
  logic [flmec_pkg::CFG_ADDR_W-1:0] cfg_addr_i      = '0;
  logic [flmec_pkg::SIZE_W-1:0]     cfg_data_i      = '0;

  int fail_count;
  int pending;

  // What the stimulus knows of the block, to build frames with valid LSBs.
  logic [flmec_pkg::SIZE_W-1:0] size_now    = flmec_pkg::FRAME_SIZE_RESET;
  logic                         mode_now    = flmec_pkg::MODE_EMBED;
  logic [31:0]                  rec_index   = '0;
  logic [63:0]                  rec_counter = '0;
  logic [63:0]                  rec_stamp   = '0;
  bit                           tx_steady   = 1'b0;
  bit                           rx_steady   = 1'b0;
  int                           beats_sent  = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  frame_lsb_metadata_embed_check dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  metadata_frame_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Result side: a random stall before each beat, with steady stretches.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        rx_steady = !rx_steady;
      end
      stall = rx_steady ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
    end
  end

  // tvalid is left high after each beat so back-to-back beats need no drop.
  task automatic send_beat(input logic [7:0] d, input logic first, input logic last,
                           input logic [31:0] idx, input logic [63:0] cnt,
                           input logic [63:0] stamp);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {stamp, cnt, idx, d};
    s_axis_tuser_i  <= first;
    s_axis_tlast_i  <= last;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    beats_sent++;
    if (first) begin
      rec_index   = idx;
      rec_counter = cnt;
      rec_stamp   = stamp;
    end
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input flmec_pkg::cfg_reg_e r,
                           input logic [flmec_pkg::SIZE_W-1:0] v);
    drain_pipeline();
    cfg_addr_i  <= r;
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    if (r == flmec_pkg::CFG_FRAME_SIZE) begin
      size_now = v;
    end else begin
      mode_now = v[0];
    end
  endtask

  // Builds a frame whose metadata LSBs match the record when keep_lsbs is set,
  // optionally with one record bit flipped and a mode switch partway through.
  task automatic send_frame(input int len, input bit with_first, input bit with_last,
                            input bit keep_lsbs, input int flip_bit, input int mode_flip_at,
                            input logic [31:0] idx, input logic [63:0] cnt,
                            input logic [63:0] stamp);
    logic [191:0] rec;
    logic [7:0]   d;
    int           spacing;
    int           k;
    bit           first;
    bit           last;
    spacing = int'(size_now) / 192;
    if (spacing == 0) begin
      spacing = 1;
    end
    rec = with_first ? {stamp, cnt, idx, flmec_pkg::META_MAGIC}
                     : {rec_stamp, rec_counter, rec_index, flmec_pkg::META_MAGIC};
    for (int p = 0; p < len; p++) begin
      if (p == mode_flip_at && p > 0) begin
        write_reg(flmec_pkg::CFG_MODE, flmec_pkg::SIZE_W'(!mode_now));
      end
      d = 8'($urandom);
      if (keep_lsbs && (p % spacing) == 0 && (p / spacing) < 192) begin
        k = p / spacing;
        d[0] = rec[k] ^ (k == flip_bit);
      end
      first = with_first && p == 0;
      last  = with_last && p == len - 1;
      if (first) begin
        send_beat(d, 1'b1, last, idx, cnt, stamp);
      end else begin
        send_beat(d, 1'b0, last, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    int goal;
    int pick;
    int variant;
    int len;
    int flip;
    int split;
    int offset;
    bit with_first;
    bit with_last;
    bit keep;
    logic [flmec_pkg::SIZE_W-1:0] size_pick;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, embed mode, bytes before any first byte.
    send_frame(3, 1'b0, 1'b1, 1'b0, -1, -1, '0, '0, '0);
    // Check mode at the reset frame size: length error.
    write_reg(flmec_pkg::CFG_MODE, flmec_pkg::SIZE_W'(flmec_pkg::MODE_CHECK));
    send_frame(2, 1'b0, 1'b1, 1'b1, -1, -1, '0, '0, '0);
    // Size below one byte per record bit; first and last on one byte.
    write_reg(flmec_pkg::CFG_FRAME_SIZE, 24'd1);
    send_frame(1, 1'b1, 1'b1, 1'b1, -1, -1, '1, '1, 64'h8000_0000_0000_0000);
    send_frame(1, 1'b1, 1'b1, 1'b1, 0, -1, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    // Largest frame size: widest spacing, short frames.
    write_reg(flmec_pkg::CFG_FRAME_SIZE, '1);
    send_frame(4, 1'b1, 1'b1, 1'b1, -1, -1, $urandom, {$urandom, $urandom},
               {$urandom, $urandom});
    write_reg(flmec_pkg::CFG_MODE, flmec_pkg::SIZE_W'(flmec_pkg::MODE_EMBED));
    send_frame(4, 1'b1, 1'b1, 1'b0, -1, -1, $urandom, {$urandom, $urandom},
               {$urandom, $urandom});
    // Byte and field extremes.
    write_reg(flmec_pkg::CFG_FRAME_SIZE, 24'd2);
    send_beat(8'h00, 1'b1, 1'b0, '0, '0, '0);
    send_beat(8'hFF, 1'b0, 1'b1, '1, '1, '1);

    goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
        size_pick = flmec_pkg::SIZE_W'($urandom_range(1, 191));
      end else if (pick < 17) begin
        size_pick = flmec_pkg::SIZE_W'($urandom_range(192, 260));
      end else if (pick < 19) begin
        size_pick = flmec_pkg::SIZE_W'($urandom_range(261, 24'hFF_FFFF));
      end else begin
        size_pick = '1;
      end
      write_reg(flmec_pkg::CFG_FRAME_SIZE, size_pick);
      if ($urandom_range(0, 3) != 0) begin
        write_reg(flmec_pkg::CFG_MODE, flmec_pkg::SIZE_W'($urandom_range(0, 1)));
      end

      repeat ($urandom_range(1, 3)) begin
        tx_steady  = ($urandom_range(0, 3) == 0);
        variant    = $urandom_range(0, 9);
        len        = (size_now <= 24'd260) ? int'(size_now) : $urandom_range(1, 48);
        with_first = 1'b1;
        with_last  = 1'b1;
        keep       = 1'b1;
        flip       = -1;
        split      = -1;
        case (variant)
          0, 1: flip = $urandom_range(0, 191);
          2: begin
            offset = $urandom_range(0, 1) ? $urandom_range(1, 2) : -$urandom_range(1, 2);
            len = (len + offset < 1) ? len + 2 : len + offset;
          end
          3: with_first = 1'b0;
          4: with_last = 1'b0;
          5: split = (len > 1) ? $urandom_range(1, len - 1) : -1;
          6: keep = 1'b0;
          default: ;
        endcase
        send_frame(len, with_first, with_last, keep, flip, split, $urandom,
                   {$urandom, $urandom}, {$urandom, $urandom});
      end
    end

    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("frame_lsb_metadata_embed_check regression: pass");
    end else begin
      $display("frame_lsb_metadata_embed_check regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("frame_lsb_metadata_embed_check regression: fail");
    $finish;
  end

endmodule
